// File: src/framebuffer_blit_convert_top_defines.svh
// assertion helpers for the blit engine top level
`ifndef FRAMEBUFFER_BLIT_CONVERT_TOP_DEFINES_SVH
`define FRAMEBUFFER_BLIT_CONVERT_TOP_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define FBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define FBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fbc_pkg.sv
package fbc_pkg;

  localparam int OFFSET_BITS_DEFAULT = 26;

  localparam int SCREEN_W    = 13;
  localparam int BPP_W       = 6;
  localparam int PITCH_W     = 15;
  localparam int COORD_W     = 16;
  localparam int PIXEL_W     = 32;
  localparam int BYTES_W     = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WRITE  = 1'b1
  } kind_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_GRAY = 2'd1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BPP           = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PITCH    = 2'd3;

  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [BYTES_W-1:0] MAX_RAW_BYTES = 3'd4;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [BPP_W-1:0]    bits_per_pixel;
    logic [PITCH_W-1:0]  line_pitch;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [1:0]         blit_mode;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [SCREEN_W-1:0] clipped_width;
    logic [SCREEN_W-1:0] clipped_height;
  } start_res_t;

  function automatic logic [BYTES_W-1:0] bytes_of(logic [BPP_W-1:0] bpp);
    return bpp[BPP_W-1:3];
  endfunction

endpackage

// File: src/fbc_in_stage.sv
module fbc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fbc_pkg::item_t in_item,
  input  logic          advance,
  output logic          q_valid,
  output fbc_pkg::item_t q_item
);

  logic accept;
  logic q_valid_next;

  assign in_ready = !q_valid || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_valid_next = q_valid;
    if (accept) begin
      q_valid_next = 1'b1;
    end else if (advance) begin
      q_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= in_item;
    end
  end

endmodule

// File: src/fbc_start_check.sv
module fbc_start_check #(
  parameter int OFFSET_BITS = fbc_pkg::OFFSET_BITS_DEFAULT
) (
  input  fbc_pkg::cfg_t       cfg,
  input  fbc_pkg::item_t      item,
  output fbc_pkg::start_res_t res,
  output logic [OFFSET_BITS-1:0] row_start
);

  logic [fbc_pkg::BYTES_W-1:0]  bytes;
  logic                         unconf;
  logic                         empty;
  logic                         gray_ok;
  logic                         bad_mode;
  logic [fbc_pkg::SCREEN_W-1:0] x13;
  logic [fbc_pkg::SCREEN_W-1:0] y13;
  logic [fbc_pkg::COORD_W:0]    x_end;
  logic [31:0]                  y_term;
  logic [31:0]                  x_term;
  logic [31:0]                  full_off;

  always_comb begin
    bytes  = fbc_pkg::bytes_of(cfg.bits_per_pixel);
    unconf = (cfg.screen_width == '0) || (cfg.screen_height == '0);
    empty  = (item.rect_x >= 16'(cfg.screen_width)) ||
             (item.rect_y >= 16'(cfg.screen_height)) ||
             (item.rect_width == '0) || (item.rect_height == '0);
    gray_ok = (cfg.bits_per_pixel == fbc_pkg::BPP_32) ||
              (cfg.bits_per_pixel == fbc_pkg::BPP_24) ||
              (cfg.bits_per_pixel == fbc_pkg::BPP_16);
    bad_mode = ((item.blit_mode != fbc_pkg::MODE_RAW) &&
                (item.blit_mode != fbc_pkg::MODE_GRAY)) ||
               ((item.blit_mode == fbc_pkg::MODE_GRAY) && !gray_ok) ||
               ((item.blit_mode == fbc_pkg::MODE_RAW) && (bytes > fbc_pkg::MAX_RAW_BYTES));

    priority if (unconf) begin
      res.status = fbc_pkg::STATUS_ERROR;
    end else if (empty) begin
      res.status = fbc_pkg::STATUS_EMPTY;
    end else if (bad_mode) begin
      res.status = fbc_pkg::STATUS_ERROR;
    end else begin
      res.status = fbc_pkg::STATUS_OK;
    end

    // clip against the right and bottom edges
    x13   = item.rect_x[fbc_pkg::SCREEN_W-1:0];
    y13   = item.rect_y[fbc_pkg::SCREEN_W-1:0];
    x_end = {1'b0, item.rect_x} + {1'b0, item.rect_width};
    res.clipped_width = (x_end > 17'(cfg.screen_width)) ? (cfg.screen_width - x13)
                      : item.rect_width[fbc_pkg::SCREEN_W-1:0];
    res.clipped_height = ((17'(item.rect_y) + 17'(item.rect_height)) >
                          17'(cfg.screen_height))
                       ? (cfg.screen_height - y13)
                       : item.rect_height[fbc_pkg::SCREEN_W-1:0];

    y_term    = 32'(y13) * 32'(cfg.line_pitch);
    x_term    = 32'(x13) * 32'(bytes);
    full_off  = y_term + x_term;
    row_start = full_off[OFFSET_BITS-1:0];
  end

endmodule

// File: src/fbc_pixel_fmt.sv
module fbc_pixel_fmt #(
  parameter int OFFSET_BITS = fbc_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                          gray_mode,
  input  logic [fbc_pkg::BPP_W-1:0]     bits_per_pixel,
  input  logic [fbc_pkg::PIXEL_W-1:0]   pixel,
  input  logic [fbc_pkg::SCREEN_W-1:0]  col,
  input  logic [OFFSET_BITS-1:0]        row_start,
  output logic [OFFSET_BITS-1:0]        offset,
  output logic [fbc_pkg::PIXEL_W-1:0]   data,
  output logic [fbc_pkg::BYTES_W-1:0]   count
);

  logic [fbc_pkg::BYTES_W-1:0] bytes;
  logic [7:0]                  v;
  logic [15:0]                 col_term;

  always_comb begin
    bytes    = fbc_pkg::bytes_of(bits_per_pixel);
    v        = pixel[7:0];
    col_term = 16'(col) * 16'(bytes);
    offset   = row_start + OFFSET_BITS'(col_term);
    count    = bytes;
    if (gray_mode) begin
      if (bits_per_pixel == fbc_pkg::BPP_16) begin
        // rgb565 from one gray byte
        data = {16'd0, v[7:3], v[7:2], v[7:3]};
      end else begin
        data = {8'd0, v, v, v};
      end
    end else begin
      unique case (bytes)
        3'd0:    data = '0;
        3'd1:    data = {24'd0, pixel[7:0]};
        3'd2:    data = {16'd0, pixel[15:0]};
        3'd3:    data = {8'd0, pixel[23:0]};
        default: data = pixel;
      endcase
    end
  end

endmodule

// File: src/framebuffer_blit_convert_top.sv
// Clipped rectangle blit engine for a linear framebuffer.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 screen width, 1 screen height, 2 bits per pixel,
// 3 line pitch in bytes. Write only while no item is in flight.
// Input channel in_valid/in_ready: a start item (cmd 0) carries the rectangle
// and mode and always returns one status item; pixel items (cmd 1) follow in
// row-major order, rect_width per source row, and return one framebuffer write
// when inside the clip, nothing otherwise.
// Output channel out_valid/out_ready: kind, status, byte_offset, write_data,
// byte_count, last.
// Path: an accepted item waits in the input register, then passes through one
// combinational step into the result register.
// Throughput: one item per cycle while the receiver does not stall; the start
// item's y * pitch multiply and the per-pixel offset add are the longest paths.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_ready drops until out_ready returns.
// Reset clears the configuration, the engine (idle) and both valid flags.
module framebuffer_blit_convert_top #(
  parameter int OFFSET_BITS = fbc_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [15:0]                     rect_x,
  input  logic [15:0]                     rect_y,
  input  logic [15:0]                     rect_width,
  input  logic [15:0]                     rect_height,
  input  logic [1:0]                      blit_mode,
  input  logic [31:0]                     pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            kind,
  output logic [1:0]                      status,
  output logic [OFFSET_BITS-1:0]          byte_offset,
  output logic [31:0]                     write_data,
  output logic [2:0]                      byte_count,
  output logic                            last
);

  `include "framebuffer_blit_convert_top_defines.svh"

  fbc_pkg::cfg_t       cfg;
  fbc_pkg::item_t      in_item;
  fbc_pkg::item_t      q_item;
  fbc_pkg::start_res_t start_res;
  logic                q_valid;
  logic                advance;
  logic [OFFSET_BITS-1:0] start_row;

  logic                         busy, busy_next;
  logic                         gray_mode, gray_mode_next;
  logic [fbc_pkg::SCREEN_W-1:0] clipped_width, clipped_width_next;
  logic [fbc_pkg::SCREEN_W-1:0] clipped_height, clipped_height_next;
  logic [15:0]                  source_width, source_width_next;
  logic [15:0]                  column_count, column_count_next;
  logic [fbc_pkg::SCREEN_W-1:0] row_count, row_count_next;
  logic [OFFSET_BITS-1:0]       row_start_offset, row_start_offset_next;

  logic [15:0]                  col_inc;
  logic [fbc_pkg::SCREEN_W-1:0] row_inc;
  logic                         wrap;
  logic                         emit;
  logic                         hit_last;
  logic                         pix_last_fire;

  logic [OFFSET_BITS-1:0]       pix_offset;
  logic [31:0]                  pix_data;
  logic [2:0]                   pix_count;

  logic                   load_out;
  fbc_pkg::kind_t         res_kind;
  fbc_pkg::status_t       res_status;
  logic [OFFSET_BITS-1:0] res_offset;
  logic [31:0]            res_data;
  logic [2:0]             res_count;
  logic                   res_last;

  fbc_pkg::kind_t         out_kind;
  fbc_pkg::status_t       out_status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbc_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width   <= cfg_data[fbc_pkg::SCREEN_W-1:0];
        fbc_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height  <= cfg_data[fbc_pkg::SCREEN_W-1:0];
        fbc_pkg::CFG_BPP:           cfg.bits_per_pixel <= cfg_data[fbc_pkg::BPP_W-1:0];
        fbc_pkg::CFG_LINE_PITCH:    cfg.line_pitch     <= cfg_data[fbc_pkg::PITCH_W-1:0];
        default:                    cfg <= cfg;
      endcase
    end
  end

  assign in_item = '{cmd: cmd, rect_x: rect_x, rect_y: rect_y, rect_width: rect_width,
                     rect_height: rect_height, blit_mode: blit_mode, pixel: pixel};

  assign advance = q_valid && (!out_valid || out_ready);

  fbc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  fbc_start_check #(.OFFSET_BITS(OFFSET_BITS)) u_start_check (
    .cfg       (cfg),
    .item      (q_item),
    .res       (start_res),
    .row_start (start_row)
  );

  fbc_pixel_fmt #(.OFFSET_BITS(OFFSET_BITS)) u_pixel_fmt (
    .gray_mode      (gray_mode),
    .bits_per_pixel (cfg.bits_per_pixel),
    .pixel          (q_item.pixel),
    .col            (column_count[fbc_pkg::SCREEN_W-1:0]),
    .row_start      (row_start_offset),
    .offset         (pix_offset),
    .data           (pix_data),
    .count          (pix_count)
  );

  always_comb begin
    busy_next             = busy;
    gray_mode_next        = gray_mode;
    clipped_width_next    = clipped_width;
    clipped_height_next   = clipped_height;
    source_width_next     = source_width;
    column_count_next     = column_count;
    row_count_next        = row_count;
    row_start_offset_next = row_start_offset;

    load_out   = 1'b0;
    res_kind   = fbc_pkg::KIND_STATUS;
    res_status = fbc_pkg::STATUS_OK;
    res_offset = '0;
    res_data   = '0;
    res_count  = '0;
    res_last   = 1'b0;

    col_inc  = column_count + 16'd1;
    row_inc  = row_count + 13'd1;
    wrap     = (col_inc == source_width);
    emit     = (column_count < 16'(clipped_width));
    hit_last = (col_inc == 16'(clipped_width)) &&
               ((14'(row_count) + 14'd1) == 14'(clipped_height));
    pix_last_fire = 1'b0;

    if (advance) begin
      if (q_item.cmd == fbc_pkg::CMD_START) begin
        load_out   = 1'b1;
        res_status = start_res.status;
        busy_next  = (start_res.status == fbc_pkg::STATUS_OK);
        if (start_res.status == fbc_pkg::STATUS_OK) begin
          gray_mode_next        = (q_item.blit_mode == fbc_pkg::MODE_GRAY);
          clipped_width_next    = start_res.clipped_width;
          clipped_height_next   = start_res.clipped_height;
          source_width_next     = q_item.rect_width;
          column_count_next     = '0;
          row_count_next        = '0;
          row_start_offset_next = start_row;
        end
      end else if (busy) begin
        column_count_next = wrap ? 16'd0 : col_inc;
        if (wrap) begin
          row_count_next        = row_inc;
          row_start_offset_next = row_start_offset + OFFSET_BITS'(cfg.line_pitch);
          if (row_inc == clipped_height) begin
            busy_next = 1'b0;
          end
        end
        if (emit) begin
          load_out   = 1'b1;
          res_kind   = fbc_pkg::KIND_WRITE;
          res_offset = pix_offset;
          res_data   = pix_data;
          res_count  = pix_count;
          res_last   = hit_last;
          if (hit_last) begin
            busy_next     = 1'b0;
            pix_last_fire = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      gray_mode        <= 1'b0;
      clipped_width    <= '0;
      clipped_height   <= '0;
      source_width     <= '0;
      column_count     <= '0;
      row_count        <= '0;
      row_start_offset <= '0;
    end else begin
      busy             <= busy_next;
      gray_mode        <= gray_mode_next;
      clipped_width    <= clipped_width_next;
      clipped_height   <= clipped_height_next;
      source_width     <= source_width_next;
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      row_start_offset <= row_start_offset_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind    <= res_kind;
      out_status  <= res_status;
      byte_offset <= res_offset;
      write_data  <= res_data;
      byte_count  <= res_count;
      last        <= res_last;
    end
  end

  assign kind   = out_kind;
  assign status = out_status;

  `FBC_ASSERT_SAME(a_row_in_clip, busy, row_count < clipped_height,
                   "row count reached clip height while busy")
  `FBC_ASSERT_SAME(a_clip_nonempty, busy, (clipped_width != '0) && (clipped_height != '0),
                   "busy with an empty clip")
  `FBC_ASSERT_NEXT(a_last_ends_blit, pix_last_fire, !busy,
                   "engine still busy after the final write")
  `FBC_ASSERT_SAME(a_status_clean,
                   out_valid && (out_kind == fbc_pkg::KIND_STATUS),
                   (write_data == '0) && (byte_count == '0) && !last && (byte_offset == '0),
                   "status item carries write fields")

endmodule
